/* rtl/core/rsa_sign_verify_engine_core_assert.svh */
// ----------------------------------------------------------------------------
// RSA sign/verify engine assertion macros
// Concurrent assertion shorthands clocked on clk_i, with and without reset.
// ----------------------------------------------------------------------------
`ifndef RSA_SIGN_VERIFY_ENGINE_CORE_ASSERT_SVH
`define RSA_SIGN_VERIFY_ENGINE_CORE_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define RSVE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rsve assertion failed");

// clocked assertion, checked during reset as well
`define RSVE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rsve reset assertion failed");

`endif

/* rtl/core/rsve_pkg.sv */
// ----------------------------------------------------------------------------
// RSA sign/verify engine package
// Widths, constants, codes and the request/response types of the reducer.
// ----------------------------------------------------------------------------
package rsve_pkg;

  localparam int unsigned MOD_WIDTH = 16;
  localparam int unsigned PROD_W    = 2 * MOD_WIDTH;
  localparam int unsigned RED_CNT_W = $clog2(PROD_W);
  localparam int unsigned EXP_CNT_W = $clog2(MOD_WIDTH);
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MOD_WIDTH-1:0] HASH_MULT       = MOD_WIDTH'(1313);
  localparam logic [MOD_WIDTH-1:0] RST_MODULUS     = MOD_WIDTH'(3233);
  localparam logic [MOD_WIDTH-1:0] RST_PRIV_EXP    = MOD_WIDTH'(1783);
  localparam logic [MOD_WIDTH-1:0] RST_PUB_EXP     = MOD_WIDTH'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_PRIV_EXP = 2'd1,
    CFG_PUB_EXP  = 2'd2
  } rsve_cfg_e;

  typedef enum logic {
    OP_SIGN   = 1'b0,
    OP_VERIFY = 1'b1
  } rsve_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_BASE,
    ST_MUL,
    ST_MUL_W,
    ST_SQR,
    ST_SQR_W,
    ST_DONE
  } rsve_state_e;

  typedef struct packed {
    logic                  start;
    logic [PROD_W-1:0]     x;
    logic [MOD_WIDTH-1:0]  n;
  } rsve_red_req_t;

  typedef struct packed {
    logic                  done;
    logic [MOD_WIDTH-1:0]  rem;
  } rsve_red_rsp_t;

endpackage

/* rtl/core/rsve_mod_reduce.sv */
// ----------------------------------------------------------------------------
// RSA sign/verify engine modular reducer
// Restoring remainder of a product-wide value by a variable modulus, one
// quotient bit per cycle; pulses done with the remainder when finished.
// ----------------------------------------------------------------------------
module rsve_mod_reduce (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rsve_pkg::rsve_red_req_t req_i,
  output rsve_pkg::rsve_red_rsp_t rsp_o
);
  import rsve_pkg::*;

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [RED_CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0]     x_q, x_d;
  logic [MOD_WIDTH-1:0]  n_q, n_d;
  logic [MOD_WIDTH-1:0]  rem_q, rem_d;
  logic [MOD_WIDTH:0]    shifted;
  logic [MOD_WIDTH:0]    diff;
  logic                  geq;

  always_comb begin
    shifted = {rem_q, x_q[PROD_W-1]};
    diff    = shifted - {1'b0, n_q};
    geq     = shifted >= {1'b0, n_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    n_d    = n_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      x_d   = req_i.x;
      n_d   = req_i.n;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = geq ? diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];
      x_d   = {x_q[PROD_W-2:0], 1'b0};
      cnt_d = cnt_q + RED_CNT_W'(1);
      if (cnt_q == RED_CNT_W'(PROD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    n_q   <= n_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* rtl/core/rsa_sign_verify_engine_core.sv */
// ----------------------------------------------------------------------------
// RSA sign/verify engine core
// Running document hash with square-and-multiply signing and verification.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present opcode_i, data_byte_i, last_i, claimed_signature_i and
//   raise start; the request is taken at a clock edge where busy is low.
//   busy stays high until the request is finished.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 modulus,
//   1 private exponent, 2 public exponent) at once; write only while idle.
//   Output: on the last byte one result appears on value_o and is_valid_o
//   for exactly one cycle, marked by result_valid_o; other bytes give none.
//   Operation: all arithmetic runs through one 32-step restoring reducer fed
//   by one 16x16 multiplier. A byte that is not last holds busy until its
//   hash reduction is done, so a new byte is never taken before the last
//   one is through. A last byte then walks the 16 exponent bits from the
//   low end: a set bit multiplies and reduces into the accumulator, and
//   every bit squares and reduces the base; verify first reduces the claimed
//   signature into the base. The next request can be taken in the strobe cycle.
//   Reset clears the hash, the sequencer and the strobe and loads the
//   default key. The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module rsa_sign_verify_engine_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [rsve_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic                                last_i,
  input  logic [rsve_pkg::MOD_WIDTH-1:0]      claimed_signature_i,
  input  logic                                cfg_we_i,
  input  logic [rsve_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsve_pkg::MOD_WIDTH-1:0]      cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [rsve_pkg::MOD_WIDTH-1:0]      value_o,
  output logic                                is_valid_o
);
  import rsve_pkg::*;

  rsve_state_e           state_q, state_d;
  logic [MOD_WIDTH-1:0]  modulus_q, priv_exp_q, pub_exp_q;
  logic [MOD_WIDTH-1:0]  hash_q, hash_d;
  logic [MOD_WIDTH-1:0]  hval_q, hval_d;
  logic [MOD_WIDTH-1:0]  base_q, base_d;
  logic [MOD_WIDTH-1:0]  acc_q, acc_d;
  logic [MOD_WIDTH-1:0]  exp_q, exp_d;
  logic [EXP_CNT_W-1:0]  bit_q, bit_d;
  logic                  op_q, op_d;
  logic                  last_q, last_d;
  logic [MOD_WIDTH-1:0]  claimed_q, claimed_d;
  logic                  res_vld_q, res_vld_d;
  logic [MOD_WIDTH-1:0]  res_val_q, res_val_d;
  logic                  res_ok_q, res_ok_d;
  logic [MOD_WIDTH-1:0]  n_eff;
  logic [MOD_WIDTH-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic                  accept;
  rsve_red_req_t         red_req;
  rsve_red_rsp_t         red_rsp;

  rsve_mod_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (red_req),
    .rsp_o  (red_rsp)
  );

  assign n_eff  = (modulus_q == '0) ? MOD_WIDTH'(1) : modulus_q;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    unique case (state_q)
      ST_MUL: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      ST_SQR: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = hash_q;
        mul_b = HASH_MULT;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= RST_MODULUS;
      priv_exp_q <= RST_PRIV_EXP;
      pub_exp_q  <= RST_PUB_EXP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODULUS:  modulus_q  <= cfg_wdata_i;
        CFG_PRIV_EXP: priv_exp_q <= cfg_wdata_i;
        CFG_PUB_EXP:  pub_exp_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    hval_d      = hval_q;
    base_d      = base_q;
    acc_d       = acc_q;
    exp_d       = exp_q;
    bit_d       = bit_q;
    op_d        = op_q;
    last_d      = last_q;
    claimed_d   = claimed_q;
    res_vld_d   = 1'b0;
    res_val_d   = res_val_q;
    res_ok_d    = res_ok_q;
    red_req.start = 1'b0;
    red_req.x     = mul_p;
    red_req.n     = n_eff;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d          = opcode_i;
          last_d        = last_i;
          claimed_d     = claimed_signature_i;
          red_req.start = 1'b1;
          red_req.x     = mul_p + PROD_W'(data_byte_i);
          state_d       = ST_HASH;
        end
      end
      ST_HASH: begin
        if (red_rsp.done) begin
          if (!last_q) begin
            hash_d  = red_rsp.rem;
            state_d = ST_IDLE;
          end else begin
            hash_d = '0;
            hval_d = red_rsp.rem;
            acc_d  = (n_eff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
            bit_d  = '0;
            if (op_q == OP_SIGN) begin
              base_d  = red_rsp.rem;
              exp_d   = priv_exp_q;
              state_d = ST_MUL;
            end else begin
              exp_d         = pub_exp_q;
              red_req.start = 1'b1;
              red_req.x     = PROD_W'(claimed_q);
              state_d       = ST_BASE;
            end
          end
        end
      end
      ST_BASE: begin
        if (red_rsp.done) begin
          base_d  = red_rsp.rem;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (exp_q[0]) begin
          red_req.start = 1'b1;
          state_d       = ST_MUL_W;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_MUL_W: begin
        if (red_rsp.done) begin
          acc_d   = red_rsp.rem;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        red_req.start = 1'b1;
        state_d       = ST_SQR_W;
      end
      ST_SQR_W: begin
        if (red_rsp.done) begin
          base_d = red_rsp.rem;
          exp_d  = {1'b0, exp_q[MOD_WIDTH-1:1]};
          bit_d  = bit_q + EXP_CNT_W'(1);
          if (bit_q == EXP_CNT_W'(MOD_WIDTH - 1)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        res_vld_d = 1'b1;
        if (op_q == OP_SIGN) begin
          res_val_d = acc_q;
          res_ok_d  = 1'b0;
        end else begin
          res_val_d = hval_q;
          res_ok_d  = (acc_q == hval_q);
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hash_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hash_q    <= hash_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hval_q    <= hval_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    exp_q     <= exp_d;
    bit_q     <= bit_d;
    op_q      <= op_d;
    last_q    <= last_d;
    claimed_q <= claimed_d;
    res_val_q <= res_val_d;
    res_ok_q  <= res_ok_d;
  end

  assign result_valid_o = res_vld_q;
  assign value_o        = res_val_q;
  assign is_valid_o     = res_ok_q;

endmodule

/* rtl/core/rsve_core_checker.sv */
// ----------------------------------------------------------------------------
// RSA sign/verify engine port checker
// Port-level timing checks on the request and result strobes.
// ----------------------------------------------------------------------------
`include "rsa_sign_verify_engine_core_assert.svh"

module rsve_core_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  `RSVE_ASSERT(a_accept_busy, start && !busy |=> busy)
  `RSVE_ASSERT(a_result_single, result_valid_o |=> !result_valid_o)
  `RSVE_ASSERT(a_result_idle, result_valid_o |-> !busy)
  `RSVE_ASSERT(a_result_after_busy, $rose(result_valid_o) |-> $past(busy))
  `RSVE_ASSERT_RST(a_reset_quiet, !rst_ni |-> !busy && !result_valid_o)

endmodule

bind rsa_sign_verify_engine_core rsve_core_checker u_rsve_core_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);

/* tb/rsa_sign_verify_engine_core_tb.sv */
// ----------------------------------------------------------------------------
// RSA sign/verify engine core testbench
// Streams byte documents through the engine under a series of keys, from
// textbook key pairs to boundary and random moduli and exponents. Computes
// the signature or the document hash and match flag of each document, or
// takes a pinned outcome, and checks each result strobe in order against it.
// ----------------------------------------------------------------------------
module rsa_sign_verify_engine_core_tb;
  import rsve_pkg::*;

  localparam int unsigned     TARGET_REQUESTS = 1300;
  localparam int unsigned     SETTLE_CYCLES   = 40;
  localparam longint unsigned CYCLE_LIMIT     = 64'd8_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  typedef logic [MOD_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  is_valid;
  } outcome_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    word_t                wdata;
    rsve_op_e             op;
    logic [BYTE_W-1:0]    data;
    logic                 last;
    word_t                sig;
    logic                 pinned;
    outcome_t             want;
  } plan_row_t;

  logic                 clk_i               = 1'b0;
  logic                 rst_ni;
  logic                 start               = 1'b0;
  logic                 busy;
  logic                 opcode_i            = 1'b0;
  logic [BYTE_W-1:0]    data_byte_i         = '0;
  logic                 last_i              = 1'b0;
  word_t                claimed_signature_i = '0;
  logic                 cfg_we_i            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i           = '0;
  word_t                cfg_wdata_i         = '0;
  logic                 result_valid_o;
  word_t                value_o;
  logic                 is_valid_o;

  word_t           reg_modulus  = RST_MODULUS;
  word_t           reg_priv     = RST_PRIV_EXP;
  word_t           reg_pub      = RST_PUB_EXP;
  word_t           doc_hash_acc = '0;
  outcome_t        expected_results [$];
  logic            pin_next     = 1'b0;
  outcome_t        pin_outcome  = '0;
  int unsigned     requests_sent = 0;
  int unsigned     fail_count    = 0;
  longint unsigned cycle_count   = 0;

  plan_row_t directed_plan [31] = '{
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'h00, 1'b1, 16'd0,     1'b1, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h00, 1'b1, 16'd0,     1'b1, '{16'd0, 1'b1}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h01, 1'b1, 16'd1,     1'b1, '{16'd1, 1'b1}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'hFF, 1'b1, 16'd0,     1'b1, '{16'd255, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'hFF, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'hFF, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'hFF, 1'b1, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h5A, 1'b0, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'hA5, 1'b1, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'h33, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_MODULUS,  16'd65535, OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h80, 1'b1, 16'h1234,  1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_PRIV_EXP, 16'd0,     OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_PUB_EXP,  16'd0,     OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'h4D, 1'b1, 16'd0,     1'b1, '{16'd1, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h01, 1'b1, 16'hABCD,  1'b1, '{16'd1, 1'b1}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h02, 1'b1, 16'd0,     1'b1, '{16'd2, 1'b0}},
    '{ROW_CFG, CFG_MODULUS,  16'd1,     OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'hC8, 1'b1, 16'd0,     1'b1, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h09, 1'b1, 16'hFFFF,  1'b1, '{16'd0, 1'b1}},
    '{ROW_CFG, CFG_MODULUS,  16'd0,     OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'h7F, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'h80, 1'b1, 16'h5555,  1'b1, '{16'd0, 1'b1}},
    '{ROW_CFG, CFG_MODULUS,  16'd65535, OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_PRIV_EXP, 16'd65535, OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_PUB_EXP,  16'd65535, OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_SPARE,    16'd1,     OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'hC8, 1'b1, 16'd0,     1'b1, '{16'd200, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_SIGN,   8'hFF, 1'b1, 16'd0,     1'b0, '{16'd0, 1'b0}},
    '{ROW_REQ, CFG_MODULUS,  16'd0,     OP_VERIFY, 8'hFF, 1'b1, 16'hFFFF,  1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG, CFG_MODULUS,  16'd3233,  OP_SIGN,   8'h00, 1'b0, 16'd0,     1'b0, '{16'd0, 1'b0}}
  };

  rsa_sign_verify_engine_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .opcode_i            (opcode_i),
    .data_byte_i         (data_byte_i),
    .last_i              (last_i),
    .claimed_signature_i (claimed_signature_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .result_valid_o      (result_valid_o),
    .value_o             (value_o),
    .is_valid_o          (is_valid_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic word_t hash_fold(word_t acc, logic [BYTE_W-1:0] b, word_t n);
    logic [63:0] m;
    m = (n == '0) ? 64'd1 : 64'(n);
    return word_t'((64'(acc) * 64'(HASH_MULT) + 64'(b)) % m);
  endfunction

  function automatic word_t mod_power(word_t base_v, word_t expo, word_t n);
    logic [63:0] acc;
    logic [63:0] sq;
    int unsigned k;
    if (n <= word_t'(1)) return '0;
    acc = 64'd1;
    sq  = 64'(base_v) % 64'(n);
    for (k = 0; k < MOD_WIDTH; k++) begin
      if (expo[k]) acc = (acc * sq) % 64'(n);
      sq = (sq * sq) % 64'(n);
    end
    return word_t'(acc);
  endfunction

  function automatic word_t boundary_exponent();
    case ($urandom_range(2))
      0: return '0;
      1: return word_t'(1);
      default: return '1;
    endcase
  endfunction

  task automatic send_request(input rsve_op_e op, input logic [BYTE_W-1:0] data,
                              input logic last, input word_t sig,
                              input logic pin, input outcome_t pin_val);
    @(negedge clk_i);
    if ((requests_sent < 500 || requests_sent >= 800) && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(negedge clk_i);
    end
    start               <= 1'b1;
    opcode_i            <= op;
    data_byte_i         <= data;
    last_i              <= last;
    claimed_signature_i <= sig;
    pin_next    = pin;
    pin_outcome = pin_val;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (busy || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin : scoreboard
    outcome_t want;
    word_t    folded;
    if (!rst_ni) begin
      reg_modulus  = RST_MODULUS;
      reg_priv     = RST_PRIV_EXP;
      reg_pub      = RST_PUB_EXP;
      doc_hash_acc = '0;
    end else begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: value %h is_valid %b", $time, value_o, is_valid_o);
        end else begin
          want = expected_results.pop_front();
          if (value_o !== want.value) begin
            fail_count++;
            $display("%0t: value mismatch: expected %h, actual %h", $time, want.value, value_o);
          end
          if (is_valid_o !== want.is_valid) begin
            fail_count++;
            $display("%0t: is_valid mismatch: expected %b, actual %b",
                     $time, want.is_valid, is_valid_o);
          end
        end
      end
      if (start && !busy) begin
        folded       = hash_fold(doc_hash_acc, data_byte_i, reg_modulus);
        doc_hash_acc = folded;
        if (last_i) begin
          doc_hash_acc = '0;
          if (pin_next)
            want = pin_outcome;
          else if (opcode_i == OP_SIGN)
            want = '{mod_power(folded, reg_priv, reg_modulus), 1'b0};
          else
            want = '{folded, mod_power(claimed_signature_i, reg_pub, reg_modulus) == folded};
          expected_results.push_back(want);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODULUS:  reg_modulus = cfg_wdata_i;
          CFG_PRIV_EXP: reg_priv    = cfg_wdata_i;
          CFG_PUB_EXP:  reg_pub     = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    word_t             key_n;
    word_t             key_d;
    word_t             key_e;
    word_t             swap_tmp;
    word_t             doc_digest;
    word_t             sig;
    logic [BYTE_W-1:0] doc [$];
    rsve_op_e          op;
    int unsigned       pick;
    int unsigned       len;
    int unsigned       i;
    int unsigned       phase_end;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        drain();
        write_reg(directed_plan[r].idx, directed_plan[r].wdata);
      end else begin
        send_request(directed_plan[r].op, directed_plan[r].data, directed_plan[r].last,
                     directed_plan[r].sig, directed_plan[r].pinned, directed_plan[r].want);
      end
    end

    while (requests_sent < TARGET_REQUESTS) begin
      drain();
      pick = $urandom_range(9);
      if (pick < 5) begin
        case ($urandom_range(2))
          0: begin
            key_n = 16'd3233; key_d = 16'd1783; key_e = 16'd7;
          end
          1: begin
            key_n = 16'd143;  key_d = 16'd103;  key_e = 16'd7;
          end
          default: begin
            key_n = 16'd55;   key_d = 16'd27;   key_e = 16'd3;
          end
        endcase
        if ($urandom_range(3) == 0) begin
          swap_tmp = key_d;
          key_d    = key_e;
          key_e    = swap_tmp;
        end
      end else if (pick < 7) begin
        key_n = word_t'($urandom_range(2, 65535));
        key_d = word_t'($urandom);
        key_e = word_t'($urandom);
      end else if (pick == 7) begin
        key_n = word_t'($urandom_range(2, 300));
        key_d = word_t'($urandom);
        key_e = word_t'($urandom);
      end else if (pick == 8) begin
        case ($urandom_range(3))
          0: key_n = '0;
          1: key_n = word_t'(1);
          2: key_n = word_t'(2);
          default: key_n = '1;
        endcase
        key_d = boundary_exponent();
        key_e = boundary_exponent();
      end else begin
        key_n = word_t'($urandom);
        key_d = word_t'($urandom);
        key_e = word_t'($urandom);
      end
      write_reg(CFG_MODULUS, key_n);
      write_reg(CFG_PRIV_EXP, key_d);
      write_reg(CFG_PUB_EXP, key_e);
      if ($urandom_range(4) == 0) write_reg(CFG_SPARE, word_t'($urandom));

      phase_end = requests_sent + $urandom_range(60, 140);
      while (requests_sent < phase_end && requests_sent < TARGET_REQUESTS) begin
        pick = $urandom_range(99);
        if (pick < 80)      len = $urandom_range(1, 6);
        else if (pick < 95) len = $urandom_range(7, 20);
        else                len = $urandom_range(21, 40);
        doc.delete();
        doc_digest = '0;
        for (i = 0; i < len; i++) begin
          doc.push_back(BYTE_W'($urandom));
          doc_digest = hash_fold(doc_digest, doc[i], key_n);
        end
        op   = rsve_op_e'($urandom_range(1));
        sig  = mod_power(doc_digest, key_d, key_n);
        pick = $urandom_range(99);
        if (pick < 20 && 32'(sig) + 32'(key_n) <= 32'hFFFF)
          sig = sig + key_n;
        else if (pick < 35)
          sig = sig ^ (word_t'(1) << $urandom_range(MOD_WIDTH - 1));
        else if (pick < 50)
          sig = word_t'($urandom);
        for (i = 0; i + 1 < len; i++)
          send_request(rsve_op_e'($urandom_range(1)), doc[i], 1'b0, word_t'($urandom),
                       1'b0, '0);
        send_request(op, doc[len - 1], 1'b1, sig, 1'b0, '0);
      end
    end

    drain();
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rsve_pkg.sv
rtl/core/rsve_mod_reduce.sv
rtl/core/rsa_sign_verify_engine_core.sv
rtl/core/rsve_core_checker.sv
tb/rsa_sign_verify_engine_core_tb.sv
